// File: src/mva_pkg.sv
// shared types, constants and register codes of the multi-source value averager
package mva_pkg;

  localparam int unsigned SOURCES_DEF    = 64;
  localparam int unsigned WINDOW_MAX_DEF = 65535;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned TIME_W = 48;
  localparam int unsigned SUM_W  = 48;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_AFTER  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE_EN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_AFTER = 3'd4;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // one source table entry
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [TIME_W-1:0]       update_time;
    logic [TIME_W-1:0]       change_time;
    logic                    ignored;
  } entry_t;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_UPD      = 6'b000010,
    S_SCAN     = 6'b000100,
    S_SCAN_END = 6'b001000,
    S_DIV_PREP = 6'b010000,
    S_DIV_WAIT = 6'b100000
  } state_e;

  // saturating-age helper: time going backwards counts as zero
  function automatic logic [TIME_W-1:0] age_of(logic [TIME_W-1:0] now,
                                               logic [TIME_W-1:0] then_t);
    age_of = (now >= then_t) ? now - then_t : '0;
  endfunction

endpackage

// File: src/multi_source_value_averager_top.sv
// top level of the multi-source value averager with its source table
//
// Averages signed Q16.16 samples. mode_select 0: samples add into a window,
// a tick transaction (opcode 1) returns sum / count and clears the window; an
// empty window gives no result. mode_select 1: each sample for a source below
// SOURCES updates its entry, then the whole table is walked (stale entries
// dropped, long-repeated values excluded) and one result always follows. A
// window sample never raises busy_o; a window tick holds it through the divide;
// a latest-value sample holds it through update, table walk and divide, the
// divide skipped when no entry is left to average. The walk reads one entry per
// cycle through the single read port; the divide uses the 48-step shared
// divider. The result strobe comes in the first cycle in which busy_o is low.
// busy_o is high while a transaction is in work; start_i is taken only when
// busy_o is low. A result is shown for one cycle with result_valid_o and must
// be taken then: there is no stall input. Configuration writes must go in only
// while busy_o is low; the block itself does not enforce it. No clearing pass
// is needed after reset: entry validity lives in flip-flops.
module multi_source_value_averager_top #(
  parameter int unsigned SOURCES          = mva_pkg::SOURCES_DEF,
  parameter int unsigned WINDOW_MAX_COUNT = mva_pkg::WINDOW_MAX_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command channel
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                opcode_i,
  input  logic [5:0]                          source_index_i,
  input  logic signed [mva_pkg::VAL_W-1:0]    sample_value_i,
  input  logic [mva_pkg::TIME_W-1:0]          now_ms_i,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [mva_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mva_pkg::CFG_DAT_W-1:0]       cfg_wdata_i,
  // result strobe
  output logic                                result_valid_o,
  output logic signed [mva_pkg::VAL_W-1:0]    average_value_o,
  output logic [mva_pkg::CNT_W-1:0]           contributing_count_o
);

  localparam int unsigned IDX_W  = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int unsigned SCAN_W = $clog2(SOURCES + 1);
  localparam int unsigned SUM_W  = mva_pkg::SUM_W;
  localparam int unsigned CNT_W  = mva_pkg::CNT_W;
  localparam int unsigned TIME_W = mva_pkg::TIME_W;
  localparam int unsigned VAL_W  = mva_pkg::VAL_W;

  // configuration registers
  logic              mode_q, round_q, stale_en_q;
  logic [31:0]       stale_after_q, repeat_after_q;

  // latched transaction
  logic [IDX_W-1:0]        idx_q;
  logic signed [VAL_W-1:0] val_q;
  logic [TIME_W-1:0]       now_q;

  // window state
  logic signed [SUM_W-1:0] win_sum_q;
  logic [CNT_W-1:0]        win_cnt_q;

  // walk accumulators, also the divider operands
  logic signed [SUM_W-1:0] acc_sum_q, acc_sum_d;
  logic [CNT_W-1:0]        acc_cnt_q, acc_cnt_d;

  mva_pkg::state_e state_q, state_d;
  logic [SCAN_W-1:0] scan_q;
  logic              ev_vld_q;
  logic [IDX_W-1:0]  ev_idx_q;

  // source table: validity in flops, payload in a memory
  logic [SOURCES-1:0]    valid_q;
  mva_pkg::entry_t       mem_q [SOURCES];
  mva_pkg::entry_t       rd_data_q, wr_data;
  logic [IDX_W-1:0]      rd_addr;
  logic                  mem_we;

  // result registers
  logic                    res_vld_q;
  logic signed [VAL_W-1:0] res_avg_q;
  logic [CNT_W-1:0]        res_cnt_q;

  // divider hookup
  logic              div_start;
  logic [SUM_W-1:0]  div_num;
  logic              div_done;
  logic [SUM_W-1:0]  div_quo;

  logic accept;
  logic in_range;
  logic changed;
  logic ev_stale;
  logic ev_use;
  logic [SUM_W-1:0] mag;
  logic [SUM_W-1:0] q_round;
  logic [SUM_W-1:0] q_neg;
  logic signed [VAL_W-1:0] avg_sat;

  assign accept   = start_i && (state_q == mva_pkg::S_IDLE);
  assign busy_o   = (state_q != mva_pkg::S_IDLE);
  assign in_range = (32'(source_index_i) < SOURCES);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= 1'b0;
      round_q        <= 1'b0;
      stale_after_q  <= '0;
      stale_en_q     <= 1'b0;
      repeat_after_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mva_pkg::CFG_MODE:         mode_q         <= cfg_wdata_i[0];
        mva_pkg::CFG_ROUND:        round_q        <= cfg_wdata_i[0];
        mva_pkg::CFG_STALE_AFTER:  stale_after_q  <= cfg_wdata_i;
        mva_pkg::CFG_STALE_EN:     stale_en_q     <= cfg_wdata_i[0];
        mva_pkg::CFG_REPEAT_AFTER: repeat_after_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // table memory: read address is the incoming source in idle, else the walk
  assign rd_addr = (state_q == mva_pkg::S_IDLE) ? IDX_W'(source_index_i)
                                                : IDX_W'(scan_q);

  // entry update from the previous contents
  assign changed = !valid_q[idx_q] || (rd_data_q.value != val_q);
  always_comb begin
    wr_data.value       = val_q;
    wr_data.update_time = now_q;
    wr_data.change_time = changed ? now_q : rd_data_q.change_time;
    wr_data.ignored     = changed ? 1'b0
        : (mva_pkg::age_of(now_q, rd_data_q.change_time) >= TIME_W'(repeat_after_q));
  end
  assign mem_we = (state_q == mva_pkg::S_UPD);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[idx_q] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // walk evaluation, one entry per cycle
  assign ev_stale = stale_en_q &&
      (mva_pkg::age_of(now_q, rd_data_q.update_time) >= TIME_W'(stale_after_q));
  assign ev_use   = ev_vld_q && valid_q[ev_idx_q] && !ev_stale && !rd_data_q.ignored;

  // divider operands: magnitude plus rounding bias
  assign mag = acc_sum_q[SUM_W-1] ? SUM_W'(-acc_sum_q) : SUM_W'(acc_sum_q);
  assign div_num = mag + (round_q ? SUM_W'({acc_cnt_q, 15'b0})
                                  : SUM_W'(acc_cnt_q[CNT_W-1:1]));
  assign div_start = (state_q == mva_pkg::S_DIV_PREP) && (acc_cnt_q != '0);

  mva_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (acc_cnt_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // whole-number rounding keeps only the integer part, then saturate
  assign q_round = round_q ? {div_quo[SUM_W-1:16], 16'b0} : div_quo;
  assign q_neg   = (q_round > SUM_W'(33'h080000000)) ? SUM_W'(33'h080000000) : q_round;
  always_comb begin
    if (acc_sum_q[SUM_W-1]) begin
      avg_sat = VAL_W'(32'd0 - q_neg[VAL_W-1:0]);
    end else if (q_round > SUM_W'(32'h7FFFFFFF)) begin
      avg_sat = 32'sh7FFFFFFF;
    end else begin
      avg_sat = q_round[VAL_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    acc_sum_d = acc_sum_q;
    acc_cnt_d = acc_cnt_q;
    unique case (state_q)
      mva_pkg::S_IDLE: begin
        if (accept) begin
          if (mode_q) begin
            if (opcode_i == mva_pkg::OP_SAMPLE && in_range) begin
              state_d = mva_pkg::S_UPD;
            end
          end else if (opcode_i == mva_pkg::OP_TICK && win_cnt_q != '0) begin
            acc_sum_d = win_sum_q;
            acc_cnt_d = win_cnt_q;
            state_d   = mva_pkg::S_DIV_PREP;
          end
        end
      end
      mva_pkg::S_UPD: begin
        acc_sum_d = '0;
        acc_cnt_d = '0;
        state_d   = mva_pkg::S_SCAN;
      end
      mva_pkg::S_SCAN: begin
        if (scan_q == SCAN_W'(SOURCES)) begin
          state_d = mva_pkg::S_SCAN_END;
        end
      end
      mva_pkg::S_SCAN_END: state_d = mva_pkg::S_DIV_PREP;
      mva_pkg::S_DIV_PREP: begin
        state_d = (acc_cnt_q == '0) ? mva_pkg::S_IDLE : mva_pkg::S_DIV_WAIT;
      end
      mva_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          state_d = mva_pkg::S_IDLE;
        end
      end
      default: state_d = mva_pkg::S_IDLE;
    endcase
    if (ev_use) begin
      acc_sum_d = acc_sum_q + SUM_W'(rd_data_q.value);
      acc_cnt_d = acc_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mva_pkg::S_IDLE;
      scan_q    <= '0;
      ev_vld_q  <= 1'b0;
      ev_idx_q  <= '0;
      valid_q   <= '0;
      win_sum_q <= '0;
      win_cnt_q <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      res_vld_q <= 1'b0;
      ev_vld_q  <= (state_q == mva_pkg::S_SCAN) && (scan_q != SCAN_W'(SOURCES));
      ev_idx_q  <= IDX_W'(scan_q);
      if (state_q == mva_pkg::S_SCAN) begin
        scan_q <= scan_q + 1'b1;
      end else begin
        scan_q <= '0;
      end
      // window transactions
      if (accept && !mode_q) begin
        if (opcode_i == mva_pkg::OP_SAMPLE) begin
          if (win_cnt_q < CNT_W'(WINDOW_MAX_COUNT)) begin
            win_sum_q <= win_sum_q + SUM_W'(sample_value_i);
            win_cnt_q <= win_cnt_q + 1'b1;
          end
        end else begin
          win_sum_q <= '0;
          win_cnt_q <= '0;
        end
      end
      // entry validity
      if (mem_we) begin
        valid_q[idx_q] <= 1'b1;
      end else if (ev_vld_q && valid_q[ev_idx_q] && ev_stale) begin
        valid_q[ev_idx_q] <= 1'b0;
      end
      // result strobe: empty table or divider finish
      if (state_q == mva_pkg::S_DIV_PREP && acc_cnt_q == '0) begin
        res_vld_q <= 1'b1;
      end else if (state_q == mva_pkg::S_DIV_WAIT && div_done) begin
        res_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_sum_q <= acc_sum_d;
    acc_cnt_q <= acc_cnt_d;
    if (accept) begin
      idx_q <= IDX_W'(source_index_i);
      val_q <= sample_value_i;
      now_q <= now_ms_i;
    end
    if (state_q == mva_pkg::S_DIV_PREP) begin
      res_avg_q <= '0;
      res_cnt_q <= '0;
    end else if (div_done) begin
      res_avg_q <= avg_sat;
      res_cnt_q <= acc_cnt_q;
    end
  end

  assign result_valid_o       = res_vld_q;
  assign average_value_o      = res_avg_q;
  assign contributing_count_o = res_cnt_q;

  // results only come from the divide phase
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> $past(state_q == mva_pkg::S_DIV_PREP || state_q == mva_pkg::S_DIV_WAIT))
    else $error("result strobe outside the divide phase");

  // updated entry is valid when the walk begins
  a_entry_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mva_pkg::S_UPD |=> valid_q[idx_q])
    else $error("updated entry not marked valid");

  // a taken window tick empties the window
  a_window_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !mode_q && opcode_i == mva_pkg::OP_TICK |=> win_cnt_q == '0)
    else $error("window not cleared by tick");

  // walk never counts more entries than the table holds
  a_walk_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mva_pkg::S_SCAN_END |-> 32'(acc_cnt_q) <= SOURCES)
    else $error("walk counted too many entries");

endmodule

// File: src/mva_div.sv
// iterative restoring divider, one quotient bit per cycle
module mva_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [mva_pkg::SUM_W-1:0]  num_i,
  input  logic [mva_pkg::CNT_W-1:0]  den_i,
  output logic                       done_o,
  output logic [mva_pkg::SUM_W-1:0]  quo_o
);

  localparam int unsigned STEP_W = $clog2(mva_pkg::SUM_W + 1);

  logic [mva_pkg::SUM_W-1:0] quo_q, quo_d;
  logic [mva_pkg::CNT_W-1:0] rem_q, rem_d;
  logic [mva_pkg::CNT_W-1:0] den_q, den_d;
  logic [STEP_W-1:0]         step_q, step_d;
  logic                      run_q, run_d;
  logic                      done_q, done_d;
  logic [mva_pkg::CNT_W:0]   trial;
  logic                      fits;

  assign trial = {rem_q, quo_q[mva_pkg::SUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    step_d = step_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      step_d = STEP_W'(mva_pkg::SUM_W);
      run_d  = 1'b1;
    end else if (run_q) begin
      rem_d  = fits ? mva_pkg::CNT_W'(trial - {1'b0, den_q}) : trial[mva_pkg::CNT_W-1:0];
      quo_d  = {quo_q[mva_pkg::SUM_W-2:0], fits};
      step_d = step_q - 1'b1;
      if (step_q == STEP_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(run_q) && !run_q)
    else $error("divider done without a running division");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q && !$past(start_i) |-> rem_q < den_q || den_q == '0)
    else $error("divider remainder not below divisor");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !run_q)
    else $error("divider started while running");

endmodule

// File: tb/tb_top.sv
// self-checking testbench of the multi-source value averager
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned VAL_W          = mva_pkg::VAL_W;
  localparam int unsigned CNT_W          = mva_pkg::CNT_W;
  localparam int unsigned TIME_W         = mva_pkg::TIME_W;
  localparam int unsigned CFG_IDX_W      = mva_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DAT_W      = mva_pkg::CFG_DAT_W;
  localparam int unsigned SOURCES_DEF    = mva_pkg::SOURCES_DEF;
  localparam int unsigned WINDOW_MAX_DEF = mva_pkg::WINDOW_MAX_DEF;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned SETTLE_CYCLES = 140;

  // expected averages and the mirrored averager state
  class avg_scoreboard;
    typedef struct {
      logic signed [VAL_W-1:0] avg;
      logic [CNT_W-1:0]        cnt;
    } avg_result_t;

    bit                      mode_latest, round_en, stale_en;
    logic [31:0]             stale_after, repeat_after;
    bit                      vld [SOURCES_DEF];
    logic signed [VAL_W-1:0] val [SOURCES_DEF];
    logic [TIME_W-1:0]       upd [SOURCES_DEF];
    logic [TIME_W-1:0]       chg [SOURCES_DEF];
    bit                      ign [SOURCES_DEF];
    longint                  win_sum;
    int unsigned             win_cnt;
    avg_result_t             pending_avgs[$];
    int                      errors;

    function new();
      foreach (vld[i]) vld[i] = 0;
      win_sum = 0;
      win_cnt = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        mva_pkg::CFG_MODE:         mode_latest = data[0];
        mva_pkg::CFG_ROUND:        round_en = data[0];
        mva_pkg::CFG_STALE_AFTER:  stale_after = data;
        mva_pkg::CFG_STALE_EN:     stale_en = data[0];
        mva_pkg::CFG_REPEAT_AFTER: repeat_after = data;
        default: ;
      endcase
    endfunction

    function logic [TIME_W-1:0] elapsed(logic [TIME_W-1:0] now, logic [TIME_W-1:0] t0);
      return (now >= t0) ? now - t0 : '0;
    endfunction

    // signed mean, half away from zero, saturated to 32 bits
    function logic [VAL_W-1:0] mean(longint s, longint unsigned c);
      bit neg;
      longint unsigned mag, q, d;
      neg = s < 0;
      mag = neg ? longint'(-s) : longint'(s);
      if (round_en) begin
        d = c * 65536;
        q = ((mag + d / 2) / d) * 65536;
      end else begin
        q = (mag + c / 2) / c;
      end
      if (neg) begin
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        return VAL_W'(-q);
      end
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return VAL_W'(q);
    endfunction

    function void note_input(logic op, logic [5:0] idx, logic signed [VAL_W-1:0] v,
                             logic [TIME_W-1:0] now);
      avg_result_t r;
      longint sum;
      longint unsigned cnt;
      if (mode_latest) begin
        if (op == mva_pkg::OP_TICK) return;
        if (!vld[idx] || val[idx] != v) begin
          chg[idx] = now;
          ign[idx] = 0;
        end else begin
          ign[idx] = elapsed(now, chg[idx]) >= {16'b0, repeat_after};
        end
        vld[idx] = 1;
        val[idx] = v;
        upd[idx] = now;
        sum = 0;
        cnt = 0;
        for (int i = 0; i < SOURCES_DEF; i++) begin
          if (!vld[i]) continue;
          if (stale_en && elapsed(now, upd[i]) >= {16'b0, stale_after}) vld[i] = 0;
          else if (!ign[i]) begin
            sum += longint'(val[i]);
            cnt++;
          end
        end
        r.avg = cnt ? mean(sum, cnt) : '0;
        r.cnt = CNT_W'(cnt);
        pending_avgs.push_back(r);
      end else if (op == mva_pkg::OP_SAMPLE) begin
        if (win_cnt < WINDOW_MAX_DEF) begin
          win_sum += longint'(v);
          win_cnt++;
        end
      end else if (win_cnt != 0) begin
        r.avg = mean(win_sum, win_cnt);
        r.cnt = CNT_W'(win_cnt);
        pending_avgs.push_back(r);
        win_sum = 0;
        win_cnt = 0;
      end
    endfunction

    function void report(string what);
      errors++;
      if (errors <= 10) $display("mismatch: %s", what);
    endfunction

    function void check_result(logic signed [VAL_W-1:0] avg, logic [CNT_W-1:0] cnt);
      avg_result_t e;
      if (pending_avgs.size() == 0) begin
        report($sformatf("unexpected result avg=%0d count=%0d", avg, cnt));
        return;
      end
      e = pending_avgs.pop_front();
      if (avg !== e.avg)
        report($sformatf("average expected %0d actual %0d", e.avg, avg));
      if (cnt !== e.cnt)
        report($sformatf("count expected %0d actual %0d", e.cnt, cnt));
    endfunction
  endclass

  logic                    clk_i, rst_ni;
  logic                    start_i, busy_o;
  logic                    opcode_i;
  logic [5:0]              source_index_i;
  logic signed [VAL_W-1:0] sample_value_i;
  logic [TIME_W-1:0]       now_ms_i;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_DAT_W-1:0]    cfg_wdata_i;
  logic                    result_valid_o;
  logic signed [VAL_W-1:0] average_value_o;
  logic [CNT_W-1:0]        contributing_count_o;

  avg_scoreboard sb = new();
  logic [TIME_W-1:0] clock_ms;   // running time stamp of the stimulus
  int unsigned cycles = 0;

  multi_source_value_averager_top dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // monitor: transactions and results are taken from pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o)
        sb.note_input(opcode_i, source_index_i, sample_value_i, now_ms_i);
      if (result_valid_o)
        sb.check_result(average_value_o, contributing_count_o);
    end
  end

  // watchdog on a hung block
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("multi_source_value_averager_top test failed");
      $finish;
    end
  end

  // all tasks start and end at a falling edge
  task automatic send(logic op, logic [5:0] idx, logic signed [VAL_W-1:0] v,
                      logic [TIME_W-1:0] now);
    start_i = 1'b1;
    opcode_i = op;
    source_index_i = idx;
    sample_value_i = v;
    now_ms_i = now;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  // mostly short gaps, a few long ones
  task automatic sender_gap(bit no_gaps);
    int unsigned r, g;
    if (no_gaps) return;
    r = $urandom_range(0, 99);
    g = (r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (g != 0) begin
      start_i = 1'b0;
      repeat (g) @(negedge clk_i);
    end
  endtask

  // drain every expectation; a tick or latest-value sample may still be in work
  task automatic wait_idle();
    start_i = 1'b0;
    @(negedge clk_i);
    while (sb.pending_avgs.size() != 0 || busy_o) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_all(bit m, bit rnd, logic [31:0] st, bit st_en, logic [31:0] rep);
    wait_idle();
    write_cfg(mva_pkg::CFG_MODE, CFG_DAT_W'(m));
    write_cfg(mva_pkg::CFG_ROUND, CFG_DAT_W'(rnd));
    write_cfg(mva_pkg::CFG_STALE_AFTER, st);
    write_cfg(mva_pkg::CFG_STALE_EN, CFG_DAT_W'(st_en));
    write_cfg(mva_pkg::CFG_REPEAT_AFTER, rep);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return VAL_W'(($urandom_range(0, 2) - 1) * 65536);  // repeats likely
    if (r < 45) return 32'h7FFF_FFFF;
    if (r < 50) return 32'h8000_0000;
    if (r < 70) return VAL_W'($signed($urandom_range(0, 400000)) - 200000);
    return VAL_W'($urandom);
  endfunction

  // time mostly creeps forward, sometimes steps back or jumps anywhere
  task automatic advance_clock();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) clock_ms += TIME_W'($urandom_range(0, 30));
    else if (r < 92) clock_ms -= TIME_W'($urandom_range(0, 20));
    else clock_ms = {16'($urandom), 32'($urandom)};
  endtask

  task automatic random_items(int n, bit no_gaps);
    logic op;
    logic [5:0] idx;
    for (int k = 0; k < n; k++) begin
      op = ($urandom_range(0, 99) < (sb.mode_latest ? 5 : 15)) ? mva_pkg::OP_TICK
                                                               : mva_pkg::OP_SAMPLE;
      idx = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 7)) : 6'($urandom_range(0, 63));
      advance_clock();
      send(op, idx, pick_value(), clock_ms);
      sender_gap(no_gaps);
      if (k == n / 2 && n > 100) wait_idle();  // hold off until all results are back
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    opcode_i = mva_pkg::OP_SAMPLE;
    source_index_i = '0;
    sample_value_i = '0;
    now_ms_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = mva_pkg::CFG_MODE;
    cfg_wdata_i = '0;
    clock_ms = 48'd100;
    sb.write_reg(mva_pkg::CFG_MODE, '0);
    sb.write_reg(mva_pkg::CFG_ROUND, '0);
    sb.write_reg(mva_pkg::CFG_STALE_AFTER, '0);
    sb.write_reg(mva_pkg::CFG_STALE_EN, '0);
    sb.write_reg(mva_pkg::CFG_REPEAT_AFTER, '0);
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // window mode: empty tick, extremes, rounding halves
    send(mva_pkg::OP_TICK, 6'd0, 32'sd0, 48'd0);
    send(mva_pkg::OP_SAMPLE, 6'd0, 32'h7FFF_FFFF, 48'd0);
    send(mva_pkg::OP_SAMPLE, 6'd63, 32'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send(mva_pkg::OP_TICK, 6'd0, 32'sd0, 48'd0);
    send(mva_pkg::OP_SAMPLE, 6'd0, 32'h8000_0000, 48'd0);
    send(mva_pkg::OP_SAMPLE, 6'd0, 32'sd1, 48'd0);
    send(mva_pkg::OP_TICK, 6'd0, 32'sd0, 48'd0);
    send(mva_pkg::OP_SAMPLE, 6'd0, 32'sd1, 48'd0);
    send(mva_pkg::OP_SAMPLE, 6'd0, 32'sd2, 48'd0);
    send(mva_pkg::OP_TICK, 6'd0, 32'sd0, 48'd0);
    set_all(0, 1, 32'd0, 0, 32'd0);
    send(mva_pkg::OP_SAMPLE, 6'd0, 32'h7FFF_FFFF, 48'd0);   // rounds past the top, saturates
    send(mva_pkg::OP_TICK, 6'd0, 32'sd0, 48'd0);
    send(mva_pkg::OP_SAMPLE, 6'd0, 32'h8000_0000, 48'd0);
    send(mva_pkg::OP_TICK, 6'd0, 32'sd0, 48'd0);
    send(mva_pkg::OP_SAMPLE, 6'd0, -32'sd98304, 48'd0);     // minus one and a half
    send(mva_pkg::OP_TICK, 6'd0, 32'sd0, 48'd0);

    // latest-value mode: first sample, repeat, ignore, time backwards, tick ignored
    set_all(1, 0, 32'd1000, 1, 32'd20);
    send(mva_pkg::OP_SAMPLE, 6'd0, 32'sd65536, 48'd1000);
    send(mva_pkg::OP_SAMPLE, 6'd63, -32'sd65536, 48'd1005);
    send(mva_pkg::OP_SAMPLE, 6'd0, 32'sd65536, 48'd1010);
    send(mva_pkg::OP_SAMPLE, 6'd0, 32'sd65536, 48'd1030);
    send(mva_pkg::OP_SAMPLE, 6'd63, 32'sd3, 48'd990);
    send(mva_pkg::OP_TICK, 6'd5, 32'sd0, 48'd1040);
    send(mva_pkg::OP_SAMPLE, 6'd5, 32'sd7, 48'd5000);
    set_all(1, 0, 32'd0, 1, 32'hFFFF_FFFF);  // everything stale at once
    send(mva_pkg::OP_SAMPLE, 6'd1, 32'sd9, 48'd5001);

    // random phases over several settings
    clock_ms = 48'd10000;
    set_all(0, 0, 32'd0, 0, 32'd0);
    random_items(230, 0);
    set_all(1, 0, 32'd1000, 1, 32'd3600000);
    random_items(200, 0);
    set_all(1, 1, 32'hFFFF_FFFF, 1, 32'd0);
    random_items(200, 1);
    set_all(0, 1, 32'd50, 0, 32'd20);
    random_items(230, 0);
    set_all(1, 0, 32'd50, 0, 32'd20);
    random_items(200, 0);
    set_all(1, 1, $urandom_range(10, 200), 1, $urandom_range(0, 60));
    random_items(200, 0);
    set_all(1, 0, $urandom, 1, $urandom);
    random_items(140, 0);

    wait_idle();
    foreach (sb.pending_avgs[i]) sb.report("expected result never came");
    if (sb.errors == 0) begin
      $display("multi_source_value_averager_top test passed");
    end else begin
      $display("multi_source_value_averager_top test failed");
    end
    $finish;
  end

endmodule
